/* hw/rtl/bpi_pkg.sv */
`default_nettype none
package bpi_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ARC_IDX_W    = 5;
   localparam int ARC_W        = 31;

   // field widths
   localparam int SPEED_W = 20;
   localparam int STEER_W = 18;
   localparam int HEAD_W  = 19;
   localparam int POS_W   = 32;
   localparam int TS_W    = 16;
   localparam int IWB_W   = 24;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 104;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   // datapath widths
   localparam int ANG_W   = 34;
   localparam int SUM_W   = 34;
   localparam int P_W     = 36;
   localparam int MUL_A_W = 37;
   localparam int MUL_B_W = 29;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int DIV_D_W   = 32;
   localparam int DIV_Q_W   = 24;
   localparam int DIV_N_W   = DIV_D_W + DIV_Q_W;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);

   localparam int ANG_SHIFT = 30 - FRAC_BITS;
   localparam int TRIG_RND  = 4;
   localparam int TAN_SHIFT = 20;
   localparam int XY_RND    = FRAC_BITS + 26;
   localparam int TAN_RND   = FRAC_BITS + TAN_SHIFT;
   localparam int INC_RND   = FRAC_BITS;

   localparam logic signed [PROD_W-1:0] XY_HALF  = PROD_W'(64'd1 << (XY_RND - 1));
   localparam logic signed [PROD_W-1:0] TAN_HALF = PROD_W'(64'd1 << (TAN_RND - 1));
   localparam logic signed [PROD_W-1:0] INC_HALF = PROD_W'(64'd1 << (INC_RND - 1));

   // angles in Q4.30
   localparam logic signed [ANG_W-1:0] PI30     = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] TWO_PI30 = 34'sd6746518852;
   localparam logic signed [ANG_W-1:0] HALF30   = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] GAIN30   = 34'sd652032874;

   // heading limits in Q16
   localparam logic signed [SUM_W-1:0] HEAD_HI  = 34'sd206215;
   localparam logic signed [SUM_W-1:0] HEAD_LO  = -34'sd205887;
   localparam logic signed [SUM_W-1:0] TWO_PI_Q = 34'sd411775;
   localparam logic signed [STEER_W-1:0] STEER_MAX = 18'sd78643;

   // floor(2^46 / turn), the turn count from it may come out one short
   localparam int TURN_RECIP_SH = 46;
   localparam logic signed [MUL_B_W-1:0] TURN_RECIP =
      MUL_B_W'((64'sd1 <<< TURN_RECIP_SH) / 64'(TWO_PI_Q));

   localparam logic signed [SUM_W-1:0] POS_MAX = 34'sd2147483647;
   localparam logic signed [SUM_W-1:0] POS_MIN = -34'sd2147483648;

   localparam logic [TS_W-1:0]           TS_RESET  = 16'd6554;
   localparam logic [IWB_W-1:0]          IWB_RESET = 24'd364089;
   localparam logic signed [POS_W-1:0]   SX_RESET  = 32'sd98304;
   localparam logic signed [POS_W-1:0]   SY_RESET  = 32'sd32768;
   localparam logic signed [HEAD_W-1:0]  SH_RESET  = 19'sd100847;

   typedef enum logic [2:0] {
      REG_TIME_STEP  = 3'd0,
      REG_INV_WB     = 3'd1,
      REG_START_X    = 3'd2,
      REG_START_Y    = 3'd3,
      REG_START_HEAD = 3'd4
   } reg_idx_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic [ARC_W-1:0] cordic_arc(input logic [ARC_IDX_W-1:0] idx);
      logic [ARC_W-1:0] a;
      case (idx)
         5'd0:  a = 31'd843314856;
         5'd1:  a = 31'd497837829;
         5'd2:  a = 31'd263043836;
         5'd3:  a = 31'd133525158;
         5'd4:  a = 31'd67021686;
         5'd5:  a = 31'd33543515;
         5'd6:  a = 31'd16775850;
         5'd7:  a = 31'd8388437;
         5'd8:  a = 31'd4194282;
         5'd9:  a = 31'd2097149;
         5'd10: a = 31'd1048575;
         5'd11: a = 31'd524287;
         5'd12: a = 31'd262143;
         5'd13: a = 31'd131071;
         5'd14: a = 31'd65535;
         5'd15: a = 31'd32767;
         5'd16: a = 31'd16383;
         5'd17: a = 31'd8191;
         5'd18: a = 31'd4095;
         5'd19: a = 31'd2047;
         5'd20: a = 31'd1023;
         5'd21: a = 31'd511;
         5'd22: a = 31'd255;
         5'd23: a = 31'd127;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/bpi_mul.sv */
`default_nettype none
module bpi_mul (
   input  logic                                  clock,
   input  logic signed [bpi_pkg::MUL_A_W-1:0]    a,
   input  logic signed [bpi_pkg::MUL_B_W-1:0]    b,
   output logic signed [bpi_pkg::PROD_W-1:0]     prod
);

   logic signed [bpi_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= bpi_pkg::PROD_W'(a) * bpi_pkg::PROD_W'(b);
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

/* hw/rtl/bpi_div.sv */
`default_nettype none
module bpi_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bpi_pkg::DIV_N_W-1:0]    dividend,
   input  logic [bpi_pkg::DIV_D_W-1:0]    divisor,
   output logic                           busy,
   output logic                           done,
   output logic [bpi_pkg::DIV_Q_W-1:0]    quotient
);

   localparam int DW = bpi_pkg::DIV_D_W;
   localparam int QW = bpi_pkg::DIV_Q_W;

   logic [DW-1:0]                    rem_ff;
   logic [QW-1:0]                    quo_ff;
   logic [DW-1:0]                    dvs_ff;
   logic [bpi_pkg::DIV_CNT_W-1:0]    cnt_ff;
   logic                             busy_ff;
   logic                             done_ff;
   logic [DW:0]                      shift_in;
   logic [DW+1:0]                    diff_in;
   logic                             qbit_in;

   // one restoring step per cycle, dividend bits shift out as quotient bits shift in
   always_comb begin
      shift_in = {rem_ff, quo_ff[QW-1]};
      diff_in  = {1'b0, shift_in} - {2'b00, dvs_ff};
      qbit_in  = !diff_in[DW+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            rem_ff  <= dividend[bpi_pkg::DIV_N_W-1:QW];
            quo_ff  <= dividend[QW-1:0];
            dvs_ff  <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= qbit_in ? diff_in[DW-1:0] : shift_in[DW-1:0];
            quo_ff <= {quo_ff[QW-2:0], qbit_in};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == bpi_pkg::DIV_CNT_W'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* hw/rtl/bpi_cordic.sv */
`default_nettype none
module bpi_cordic (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [bpi_pkg::HEAD_W-1:0]    angle,
   output logic                                 done,
   output logic signed [bpi_pkg::ANG_W-1:0]     cos_out,
   output logic signed [bpi_pkg::ANG_W-1:0]     sin_out
);

   localparam int AW = bpi_pkg::ANG_W;

   typedef enum logic [1:0] {C_IDLE, C_WRAP, C_FOLD, C_ROT} state_type;

   state_type                       state_ff;
   logic signed [AW-1:0]            x_ff, y_ff, z_ff;
   logic signed [AW-1:0]            x_in, y_in, z_in;
   logic                            neg_ff;
   logic                            done_ff;
   logic [bpi_pkg::STEP_W-1:0]      step_ff;
   logic signed [AW-1:0]            arc_w, xs_w, ys_w;

   always_comb begin
      arc_w = {{(AW - bpi_pkg::ARC_W){1'b0}},
               bpi_pkg::cordic_arc(bpi_pkg::ARC_IDX_W'(step_ff))};
      xs_w  = x_ff >>> step_ff;
      ys_w  = y_ff >>> step_ff;
      if (!z_ff[AW-1]) begin
         x_in = x_ff - ys_w;
         y_in = y_ff + xs_w;
         z_in = z_ff - arc_w;
      end else begin
         x_in = x_ff + ys_w;
         y_in = y_ff - xs_w;
         z_in = z_ff + arc_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         neg_ff   <= 1'b0;
         step_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  z_ff     <= AW'(angle) <<< bpi_pkg::ANG_SHIFT;
                  state_ff <= C_WRAP;
               end
            end
            // bring into [-pi, pi)
            C_WRAP: begin
               if (z_ff >= bpi_pkg::PI30) begin
                  z_ff <= z_ff - bpi_pkg::TWO_PI30;
               end else if (z_ff < -bpi_pkg::PI30) begin
                  z_ff <= z_ff + bpi_pkg::TWO_PI30;
               end
               state_ff <= C_FOLD;
            end
            // fold into [-pi/2, pi/2], negate the result later
            C_FOLD: begin
               if (z_ff > bpi_pkg::HALF30) begin
                  z_ff   <= z_ff - bpi_pkg::PI30;
                  neg_ff <= 1'b1;
               end else if (z_ff < -bpi_pkg::HALF30) begin
                  z_ff   <= z_ff + bpi_pkg::PI30;
                  neg_ff <= 1'b1;
               end else begin
                  neg_ff <= 1'b0;
               end
               x_ff     <= bpi_pkg::GAIN30;
               y_ff     <= '0;
               step_ff  <= '0;
               state_ff <= C_ROT;
            end
            C_ROT: begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               z_ff    <= z_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == bpi_pkg::STEP_W'(bpi_pkg::CORDIC_STEPS - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= C_IDLE;
               end
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule
`default_nettype wire

/* hw/rtl/bicycle_pose_integrator.sv */
`default_nettype none
// channel   ports                      beat contents (low bits first)
// req       req_tvalid/tready/tdata    speed, steer_angle, restart
// rsp       rsp_tvalid/tready/tdata    pos_x, pos_y, heading_out, speed_out
// csr       csr_p*                     time_step, inverse_wheelbase, start x/y/heading
//
// a tick runs two 16-step cordic passes (heading, then steering) and the
// 24-step divider for tan, plus the wrap states when the heading wraps.
// a new beat is taken only when the sequencer is idle; the result waits in the
// output register and the sequencer holds before writing it while rsp stalls.
// reset loads the registers' reset values and the start pose.
module bicycle_pose_integrator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bpi_pkg::REQ_W-1:0]     req_tdata,   // speed, steer_angle, restart, pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bpi_pkg::RSP_W-1:0]     rsp_tdata,   // pos_x, pos_y, heading_out, speed_out, pad
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bpi_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [bpi_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [bpi_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int SPW = bpi_pkg::SPEED_W;
   localparam int STW = bpi_pkg::STEER_W;
   localparam int HW  = bpi_pkg::HEAD_W;
   localparam int PW  = bpi_pkg::POS_W;
   localparam int SW  = bpi_pkg::SUM_W;
   localparam int AW  = bpi_pkg::ANG_W;
   localparam int MA  = bpi_pkg::MUL_A_W;
   localparam int MB  = bpi_pkg::MUL_B_W;

   typedef enum logic [4:0] {
      S_IDLE, S_P, S_P2, S_CS_WAIT, S_MX, S_MY, S_MY2, S_ST_WAIT, S_DIV,
      S_MQ, S_MQ2, S_MI, S_MI2, S_WRAP, S_KDIV, S_KQ, S_MK, S_MK2, S_FIX, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [bpi_pkg::TS_W-1:0]    ts_ff;
   logic [bpi_pkg::IWB_W-1:0]   iwb_ff;
   logic signed [PW-1:0]        sx_ff, sy_ff;
   logic signed [HW-1:0]        sh_ff;
   logic                        csr_wr;

   // working registers
   logic signed [SPW-1:0]        v_ff;
   logic signed [STW-1:0]        st_ff, st_in, st_raw;
   logic signed [bpi_pkg::P_W-1:0] p_ff;
   logic signed [MB-1:0]         cr_ff, sr_ff, tan_ff, tan_mag, tan_in;
   logic signed [MA-1:0]         q_ff;
   logic [bpi_pkg::DIV_Q_W-1:0]  k_ff, k_in;
   logic signed [SW-1:0]         h_ff;
   logic                         up_ff, tneg_ff;
   logic signed [PW-1:0]         pose_x_ff, pose_y_ff;
   logic signed [HW-1:0]         pose_h_ff;
   logic                         rsp_tvalid_ff;
   logic [bpi_pkg::RSP_W-1:0]    rsp_tdata_ff;

   // units: shared multiplier and cordic, and the divider
   logic signed [MA-1:0]            mul_a;
   logic signed [MB-1:0]            mul_b;
   logic signed [bpi_pkg::PROD_W-1:0] prod;
   logic                            cordic_start, cordic_done;
   logic signed [HW-1:0]            cordic_angle;
   logic signed [AW-1:0]            cordic_cos, cordic_sin, ss_abs;
   logic                            div_start, div_busy, div_done;
   logic [bpi_pkg::DIV_N_W-1:0]     div_dividend;
   logic [bpi_pkg::DIV_D_W-1:0]     div_divisor;
   logic [bpi_pkg::DIV_Q_W-1:0]     div_quot;

   // derived values
   logic signed [SW-1:0]  rnd_xy, pos_sum, inc_w, h_in, kp_w, wrap_hi_w, wrap_lo_w;
   logic signed [PW-1:0]  pos_sat;
   logic signed [MB-1:0]  trig_c_r, trig_s_r;
   logic signed [MA-1:0]  q_in;
   logic                  out_free;

   //------------------------------------------------------------------ csr
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (bpi_pkg::reg_idx_type'(csr_paddr[bpi_pkg::CSR_AW-1:2]))
         bpi_pkg::REG_TIME_STEP:  csr_prdata = {{(32 - bpi_pkg::TS_W){1'b0}}, ts_ff};
         bpi_pkg::REG_INV_WB:     csr_prdata = {{(32 - bpi_pkg::IWB_W){1'b0}}, iwb_ff};
         bpi_pkg::REG_START_X:    csr_prdata = sx_ff;
         bpi_pkg::REG_START_Y:    csr_prdata = sy_ff;
         bpi_pkg::REG_START_HEAD: csr_prdata = {{(32 - HW){1'b0}}, sh_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff  <= bpi_pkg::TS_RESET;
         iwb_ff <= bpi_pkg::IWB_RESET;
         sx_ff  <= bpi_pkg::SX_RESET;
         sy_ff  <= bpi_pkg::SY_RESET;
         sh_ff  <= bpi_pkg::SH_RESET;
      end else if (csr_wr) begin
         case (bpi_pkg::reg_idx_type'(csr_paddr[bpi_pkg::CSR_AW-1:2]))
            bpi_pkg::REG_TIME_STEP:  ts_ff  <= csr_pwdata[bpi_pkg::TS_W-1:0];
            bpi_pkg::REG_INV_WB:     iwb_ff <= csr_pwdata[bpi_pkg::IWB_W-1:0];
            bpi_pkg::REG_START_X:    sx_ff  <= csr_pwdata;
            bpi_pkg::REG_START_Y:    sy_ff  <= csr_pwdata;
            bpi_pkg::REG_START_HEAD: sh_ff  <= csr_pwdata[HW-1:0];
            default: ;
         endcase
      end
   end

   //------------------------------------------------------------------ units
   bpi_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   bpi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (cordic_angle),
      .done    (cordic_done),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin)
   );

   bpi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      unique case (state_ff)
         S_P: begin
            mul_a = MA'(v_ff);
            mul_b = {{(MB - bpi_pkg::TS_W){1'b0}}, ts_ff};
         end
         S_MX: begin
            mul_a = MA'(p_ff);
            mul_b = cr_ff;
         end
         S_MY: begin
            mul_a = MA'(p_ff);
            mul_b = sr_ff;
         end
         S_MQ: begin
            mul_a = MA'(p_ff);
            mul_b = tan_ff;
         end
         S_MI: begin
            mul_a = q_ff;
            mul_b = {{(MB - bpi_pkg::IWB_W){1'b0}}, iwb_ff};
         end
         S_KDIV: begin
            mul_a = up_ff ? MA'(wrap_lo_w) : MA'(wrap_hi_w);
            mul_b = bpi_pkg::TURN_RECIP;
         end
         S_MK: begin
            mul_a = {{(MA - bpi_pkg::DIV_Q_W){1'b0}}, k_ff};
            mul_b = MB'(bpi_pkg::TWO_PI_Q);
         end
         default: begin
            mul_a = MA'(p_ff);
            mul_b = '0;
         end
      endcase
   end

   assign cordic_start = (state_ff == S_P) || (state_ff == S_CS_WAIT && cordic_done);
   assign cordic_angle = (state_ff == S_P) ? pose_h_ff : HW'(st_ff);

   always_comb begin
      ss_abs    = cordic_sin[AW-1] ? -cordic_sin : cordic_sin;
      wrap_hi_w = h_ff - bpi_pkg::HEAD_HI + bpi_pkg::TWO_PI_Q - SW'(1);
      wrap_lo_w = bpi_pkg::HEAD_LO - h_ff + bpi_pkg::TWO_PI_Q - SW'(1);
      div_start    = (state_ff == S_ST_WAIT) && cordic_done;
      div_dividend = {{(bpi_pkg::DIV_N_W - AW){1'b0}}, ss_abs} << bpi_pkg::TAN_SHIFT;
      div_divisor  = (cordic_cos < AW'(1)) ? bpi_pkg::DIV_D_W'(1)
                                           : cordic_cos[bpi_pkg::DIV_D_W-1:0];
   end

   //------------------------------------------------------------------ datapath
   always_comb begin
      st_raw   = req_tdata[SPW +: STW];
      if (st_raw > bpi_pkg::STEER_MAX) begin
         st_in = bpi_pkg::STEER_MAX;
      end else if (st_raw < -bpi_pkg::STEER_MAX) begin
         st_in = -bpi_pkg::STEER_MAX;
      end else begin
         st_in = st_raw;
      end
      trig_c_r = MB'((cordic_cos + AW'(8)) >>> bpi_pkg::TRIG_RND);
      trig_s_r = MB'((cordic_sin + AW'(8)) >>> bpi_pkg::TRIG_RND);
      rnd_xy   = SW'((prod + bpi_pkg::XY_HALF) >>> bpi_pkg::XY_RND);
      pos_sum  = ((state_ff == S_MY) ? SW'(pose_x_ff) : SW'(pose_y_ff)) + rnd_xy;
      if (pos_sum > bpi_pkg::POS_MAX) begin
         pos_sat = PW'(bpi_pkg::POS_MAX);
      end else if (pos_sum < bpi_pkg::POS_MIN) begin
         pos_sat = PW'(bpi_pkg::POS_MIN);
      end else begin
         pos_sat = PW'(pos_sum);
      end
      q_in    = MA'((prod + bpi_pkg::TAN_HALF) >>> bpi_pkg::TAN_RND);
      inc_w   = SW'((prod + bpi_pkg::INC_HALF) >>> bpi_pkg::INC_RND);
      h_in    = SW'(pose_h_ff) + inc_w;
      kp_w    = SW'(prod);
      k_in    = bpi_pkg::DIV_Q_W'(prod >>> bpi_pkg::TURN_RECIP_SH);
      tan_mag = {{(MB - bpi_pkg::DIV_Q_W){1'b0}}, div_quot};
      tan_in  = tneg_ff ? -tan_mag : tan_mag;
   end

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         pose_x_ff     <= bpi_pkg::SX_RESET;
         pose_y_ff     <= bpi_pkg::SY_RESET;
         pose_h_ff     <= bpi_pkg::SH_RESET;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  v_ff  <= req_tdata[SPW-1:0];
                  st_ff <= st_in;
                  if (req_tdata[SPW + STW]) begin
                     pose_x_ff <= sx_ff;
                     pose_y_ff <= sy_ff;
                     pose_h_ff <= sh_ff;
                  end
                  state_ff <= S_P;
               end
            end
            S_P:  state_ff <= S_P2;
            S_P2: begin
               p_ff     <= bpi_pkg::P_W'(prod);
               state_ff <= S_CS_WAIT;
            end
            S_CS_WAIT: begin
               if (cordic_done) begin
                  cr_ff    <= trig_c_r;
                  sr_ff    <= trig_s_r;
                  state_ff <= S_MX;
               end
            end
            S_MX: state_ff <= S_MY;
            S_MY: begin
               pose_x_ff <= pos_sat;
               state_ff  <= S_MY2;
            end
            S_MY2: begin
               pose_y_ff <= pos_sat;
               state_ff  <= S_ST_WAIT;
            end
            S_ST_WAIT: begin
               if (cordic_done) begin
                  tneg_ff  <= cordic_sin[AW-1];
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  tan_ff   <= tan_in;
                  state_ff <= S_MQ;
               end
            end
            S_MQ:  state_ff <= S_MQ2;
            S_MQ2: begin
               q_ff     <= q_in;
               state_ff <= S_MI;
            end
            S_MI:  state_ff <= S_MI2;
            S_MI2: begin
               h_ff     <= h_in;
               state_ff <= S_WRAP;
            end
            // whole turns to remove come from a reciprocal multiply
            S_WRAP: begin
               up_ff <= (h_ff < bpi_pkg::HEAD_LO);
               if (h_ff > bpi_pkg::HEAD_HI || h_ff < bpi_pkg::HEAD_LO) begin
                  state_ff <= S_KDIV;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_KDIV: state_ff <= S_KQ;
            S_KQ: begin
               k_ff     <= k_in;
               state_ff <= S_MK;
            end
            S_MK:  state_ff <= S_MK2;
            S_MK2: begin
               h_ff     <= up_ff ? (h_ff + kp_w) : (h_ff - kp_w);
               state_ff <= S_FIX;
            end
            // one more turn when the count came out one short
            S_FIX: begin
               if (up_ff && h_ff < bpi_pkg::HEAD_LO) begin
                  h_ff <= h_ff + bpi_pkg::TWO_PI_Q;
               end else if (!up_ff && h_ff > bpi_pkg::HEAD_HI) begin
                  h_ff <= h_ff - bpi_pkg::TWO_PI_Q;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  pose_h_ff     <= HW'(h_ff);
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {1'b0, v_ff, HW'(h_ff), pose_y_ff, pose_x_ff};
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   //------------------------------------------------------------------ checks
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[82:64]) >= HW'(bpi_pkg::HEAD_LO) &&
                      $signed(rsp_tdata[82:64]) <= HW'(bpi_pkg::HEAD_HI)))
      else $error("heading left its wrap range");

   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while a tick is in flight");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule
`default_nettype wire
